/* src/rnf_pkg.sv */
// Shared constants for the radix number formatter: transaction modes and
// the character codes used by the alphabet checks. No dependencies.
`default_nettype none

package rnf_pkg;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_CONVERT = 2'd2;

    localparam logic [7:0] SYM_LOW   = 8'h21;
    localparam logic [7:0] SYM_HIGH  = 8'h7E;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;

    localparam int SEEN_DEPTH = 128;

endpackage

`default_nettype wire

/* src/radix_number_formatter.sv */
// Radix number formatter: loads a digit alphabet and writes signed values
// as text in the radix given by that alphabet. Depends on rnf_pkg.
//
// Clear and append transactions complete as they are accepted. A convert
// transaction runs the bit-serial divider once per digit, looks the remainder up
// in the alphabet and stores the digit, then reads the digits back from the digit buffer; the sign goes out first.
// The input is ready only while no conversion is in progress. Reset clears
// the alphabet state and the output register; the memories need no clearing.
`default_nettype none

module radix_number_formatter
    import rnf_pkg::*;
#(
    parameter int MAX_SYMBOLS = 94,
    parameter int VALUE_BITS  = 32,
    localparam int S_TDATA_W  = ((VALUE_BITS + 10 + 7) / 8) * 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [S_TDATA_W-1:0]  s_tdata,   // mode[1:0], symbol[9:2], value, zero fill
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [7:0]           m_tdata,   // out_char[6:0], zero fill
    output logic                 m_tlast
);

    localparam int ALPH_AW = $clog2(MAX_SYMBOLS);
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int DIG_AW  = $clog2(VALUE_BITS);
    localparam int NDIG_W  = $clog2(VALUE_BITS + 1);
    localparam int BIT_CW  = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV       = 3'd1;
    localparam logic [2:0] ST_LOOK      = 3'd2;
    localparam logic [2:0] ST_STORE     = 3'd3;
    localparam logic [2:0] ST_EMIT_RD   = 3'd4;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  bad_reg, bad_next;
    logic [SEEN_DEPTH-1:0] seen_reg, seen_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [BIT_CW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [NDIG_W-1:0]     ndig_reg, ndig_next;
    logic                  sign_pend_reg, sign_pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    // Alphabet and digit buffer memories.
    logic [6:0] alph_mem [MAX_SYMBOLS];
    logic [6:0] dbuf_mem [VALUE_BITS];
    logic [6:0] alph_rd_reg;
    logic [6:0] dbuf_rd_reg;
    logic       alph_we, alph_re, dbuf_we, dbuf_re;
    logic [NDIG_W-1:0] ndig_m1;

    logic [1:0]            in_mode;
    logic [7:0]            in_symbol;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_fire;
    logic                  out_free;
    logic                  sym_bad;
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        diff;
    logic                  fits;

    assign in_mode   = s_tdata[1:0];
    assign in_symbol = s_tdata[9:2];
    assign in_value  = s_tdata[10 +: VALUE_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    assign sym_bad = (in_symbol < SYM_LOW) || (in_symbol > SYM_HIGH)
                  || (in_symbol == SYM_PLUS) || (in_symbol == SYM_MINUS)
                  || seen_reg[in_symbol[6:0]];

    // One restoring division step: shift the next magnitude bit into the remainder.
    assign trial = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, count_reg};
    assign fits  = (trial >= {1'b0, count_reg});

    assign ndig_m1 = ndig_reg - NDIG_W'(1);

    assign alph_we = in_fire && (in_mode == MODE_APPEND)
                  && (count_reg < CNT_W'(MAX_SYMBOLS));
    assign alph_re = (state_reg == ST_LOOK);
    assign dbuf_we = (state_reg == ST_STORE);
    assign dbuf_re = (state_reg == ST_EMIT_RD);

    always_ff @(posedge aclk) begin
        if (alph_we) begin
            alph_mem[count_reg[ALPH_AW-1:0]] <= in_symbol[6:0];
        end
        if (alph_re) begin
            alph_rd_reg <= alph_mem[rem_reg[ALPH_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (dbuf_we) begin
            dbuf_mem[ndig_reg[DIG_AW-1:0]] <= alph_rd_reg;
        end
        if (dbuf_re) begin
            dbuf_rd_reg <= dbuf_mem[ndig_m1[DIG_AW-1:0]];
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;
        seen_next      = seen_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        ndig_next      = ndig_reg;
        sign_pend_next = sign_pend_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // The sign goes out as soon as the output register is free.
        if (sign_pend_reg && out_free) begin
            out_valid_next = 1'b1;
            out_char_next  = SYM_MINUS[6:0];
            out_last_next  = 1'b0;
            sign_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_mode)
                        MODE_CLEAR: begin
                            count_next = '0;
                            bad_next   = 1'b0;
                            seen_next  = '0;
                        end
                        MODE_APPEND: begin
                            if (sym_bad || count_reg >= CNT_W'(MAX_SYMBOLS)) begin
                                bad_next = 1'b1;
                            end
                            if (count_reg < CNT_W'(MAX_SYMBOLS)) begin
                                seen_next[in_symbol[6:0]] = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_CONVERT: begin
                            if (count_reg >= CNT_W'(2) && !bad_reg) begin
                                sign_pend_next = in_value[VALUE_BITS-1];
                                mag_next       = in_value[VALUE_BITS-1]
                                               ? (~in_value + VALUE_BITS'(1)) : in_value;
                                rem_next       = '0;
                                bit_cnt_next   = '0;
                                ndig_next      = '0;
                                state_next     = ST_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                mag_next = {mag_reg[VALUE_BITS-2:0], fits};
                rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                bit_cnt_next = bit_cnt_reg + BIT_CW'(1);
                if (bit_cnt_reg == BIT_CW'(VALUE_BITS - 1)) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_STORE;
            end
            ST_STORE: begin
                ndig_next = ndig_reg + NDIG_W'(1);
                if (mag_reg == '0) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (out_free && !sign_pend_reg) begin
                    out_valid_next = 1'b1;
                    out_char_next  = dbuf_rd_reg;
                    out_last_next  = (ndig_m1 == '0);
                    ndig_next      = ndig_m1;
                    state_next     = (ndig_m1 == '0) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            seen_reg      <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            seen_reg      <= seen_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
        ndig_reg     <= ndig_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

/* src/rnf_checker.sv */
// Port-level checks for the radix number formatter and the bind that
// attaches them to the top level. Depends on rnf_pkg.
`default_nettype none

module rnf_port_checks
    import rnf_pkg::*;
(
    input wire       aclk,
    input wire       aresetn,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast
);

    // A stalled result transaction keeps its character and flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Characters are 7-bit; the fill bit stays zero.
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("nonzero fill bit in result");

    // A usable alphabet never holds a minus, so a minus is always a sign.
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:0] == SYM_MINUS[6:0]) |-> !m_tlast)
        else $error("sign flagged as final character");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind radix_number_formatter rnf_port_checks u_rnf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* bench/rnf_checker.sv */
// Checker for the radix number formatter: watches both stream channels, keeps its own
// copy of the digit alphabet, predicts every emitted character and compares it.
// Depends on rnf_pkg for the transaction modes and character codes.
`default_nettype none

module rnf_checker
    import rnf_pkg::*;
#(
    parameter int MAX_SYMBOLS = 94,
    parameter int VALUE_BITS  = 32,
    parameter int S_TDATA_W   = 48
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    input  wire                 s_tready,
    input  wire [S_TDATA_W-1:0] s_tdata,   // mode[1:0], symbol[9:2], value, zero fill
    input  wire                 m_tvalid,
    input  wire                 m_tready,
    input  wire [7:0]           m_tdata,   // out_char[6:0], zero fill
    input  wire                 m_tlast,
    output int                  mismatches,
    output int                  chars_pending
);

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_chars[$];

    logic [6:0] digit_set [MAX_SYMBOLS];
    logic       used_symbol [SEEN_DEPTH];
    int         digit_count;
    logic       set_broken;
    int         error_count;

    task automatic report_mismatch(input string what);
        $display("%0t rnf_checker: %s", $time, what);
        error_count++;
    endtask

    task automatic expect_char(input logic [6:0] ch, input logic last);
        text_char_t c;
        c.ch   = ch;
        c.last = last;
        expected_chars.push_back(c);
    endtask

    task automatic forget_alphabet();
        foreach (used_symbol[i]) used_symbol[i] = 1'b0;
        digit_count = 0;
        set_broken  = 1'b0;
    endtask

    // A rejected symbol still takes a slot while there is room.
    task automatic load_symbol(input logic [7:0] sym);
        if (sym < SYM_LOW || sym > SYM_HIGH || sym == SYM_PLUS || sym == SYM_MINUS) begin
            set_broken = 1'b1;
        end else if (used_symbol[sym[6:0]]) begin
            set_broken = 1'b1;
        end
        if (digit_count >= MAX_SYMBOLS) begin
            set_broken = 1'b1;
        end else begin
            digit_set[digit_count] = sym[6:0];
            used_symbol[sym[6:0]]  = 1'b1;
            digit_count++;
        end
    endtask

    task automatic format_value(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [6:0]            digits[$];
        if (digit_count < 2 || set_broken) return;
        if (value[VALUE_BITS-1]) begin
            expect_char(SYM_MINUS[6:0], 1'b0);
            // The most negative value wraps to its own bit pattern, read unsigned.
            magnitude = ~value + 1'b1;
        end else begin
            magnitude = value;
        end
        do begin
            digits.push_front(digit_set[magnitude % digit_count]);
            magnitude = magnitude / digit_count;
        end while (magnitude != 0);
        foreach (digits[i]) expect_char(digits[i], i == digits.size() - 1);
    endtask

    task automatic check_char();
        text_char_t want;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %02h last %0b", m_tdata, m_tlast));
            return;
        end
        want = expected_chars.pop_front();
        if (m_tdata !== {1'b0, want.ch})
            report_mismatch($sformatf("character %02h, expected %02h", m_tdata, want.ch));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last flag %0b, expected %0b", m_tlast, want.last));
    endtask

    initial begin
        error_count = 0;
        forget_alphabet();
    end

    // Results are checked before the new transaction is predicted, since a
    // transaction can never produce a character at its own acceptance edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chars.delete();
            forget_alphabet();
        end else begin
            if (m_tvalid && m_tready) check_char();
            if (s_tvalid && s_tready) begin
                case (s_tdata[1:0])
                    MODE_CLEAR:   forget_alphabet();
                    MODE_APPEND:  load_symbol(s_tdata[9:2]);
                    MODE_CONVERT: format_value(s_tdata[VALUE_BITS+9:10]);
                    default: ;
                endcase
            end
        end
        mismatches    <= error_count;
        chars_pending <= expected_chars.size();
    end

endmodule

`default_nettype wire

/* bench/radix_number_formatter_test.sv */
// Top of the radix number formatter bench: clock, reset, stimulus, output stalls
// and the verdict. Depends on rnf_pkg, radix_number_formatter and rnf_checker.
`default_nettype none

module radix_number_formatter_test;
    import rnf_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam int TDATA_W    = ((VALUE_BITS + 10 + 7) / 8) * 8;
    localparam int POOL_SIZE  = 92;
    localparam int ITEM_GOAL  = 180;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    int                 mismatches;
    int                 chars_pending;

    int         items_sent;
    logic       steady_sender;
    logic [7:0] symbol_pool [POOL_SIZE];

    radix_number_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rnf_checker #(
        .VALUE_BITS (VALUE_BITS),
        .S_TDATA_W  (TDATA_W)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .chars_pending (chars_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic pause_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 50) return;
        gap = (r < 88) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [7:0] symbol,
                             input logic [VALUE_BITS-1:0] value);
        s_tdata  <= {{(TDATA_W - VALUE_BITS - 10){1'b0}}, value, symbol, mode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (mode != MODE_IGNORED) items_sent++;
        pause_sender();
    endtask

    // Rebuilds the printable symbols other than the signs, in random order.
    task automatic shuffle_pool();
        int n;
        int j;
        logic [7:0] t;
        n = 0;
        for (int c = SYM_LOW; c <= SYM_HIGH; c++) begin
            if (c != SYM_PLUS && c != SYM_MINUS) begin
                symbol_pool[n] = c[7:0];
                n++;
            end
        end
        for (int i = POOL_SIZE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = symbol_pool[i];
            symbol_pool[i] = symbol_pool[j];
            symbol_pool[j] = t;
        end
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned k;
        k = $urandom_range(0, VALUE_BITS - 1);
        case ($urandom_range(0, 9))
            0: pick_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: pick_value = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
            2, 3: pick_value = $urandom_range(0, 1000);
            4: pick_value = -$urandom_range(1, 1000);
            5: pick_value = 32'd1 << k;
            6: pick_value = -(32'd1 << k);
            default: pick_value = $urandom;
        endcase
    endfunction

    // Out of range, a sign, or a repeat of one already loaded.
    function automatic logic [7:0] pick_bad_symbol(input int loaded);
        case ($urandom_range(0, 4))
            0: pick_bad_symbol = 8'($urandom_range(0, SYM_LOW - 1));
            1: pick_bad_symbol = 8'($urandom_range(SYM_HIGH + 1, 255));
            2: pick_bad_symbol = SYM_PLUS;
            3: pick_bad_symbol = SYM_MINUS;
            default: pick_bad_symbol = (loaded > 0) ? symbol_pool[$urandom_range(0, loaded - 1)]
                                                    : SYM_MINUS;
        endcase
    endfunction

    task automatic convert_some(input int count);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_IGNORED, 8'($urandom_range(0, 255)), $urandom);
            send_item(MODE_CONVERT, 8'($urandom_range(0, 255)), pick_value());
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            int r;
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            r = $urandom_range(0, 99);
            if (r >= 25) begin
                m_tready <= 1'b0;
                repeat ((r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60))
                    @(posedge aclk);
            end
        end
    end

    initial begin
        int n;
        int bad_at;
        int r;
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        items_sent    = 0;
        steady_sender = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: unusable alphabets, radix-2 extremes, ignored mode,
        // edge-of-range symbols, and a sign, a repeat and an out-of-range symbol as bad appends.
        send_item(MODE_CLEAR, 8'h00, 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'd5);
        send_item(MODE_APPEND, "0", 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'd5);
        send_item(MODE_APPEND, "1", 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'h8000_0000);
        send_item(MODE_CONVERT, 8'h00, 32'h7FFF_FFFF);
        send_item(MODE_CONVERT, 8'h00, 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'hFFFF_FFFF);
        send_item(MODE_IGNORED, 8'hFF, 32'hFFFF_FFFF);
        send_item(MODE_APPEND, SYM_LOW, 32'd0);
        send_item(MODE_APPEND, SYM_HIGH, 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'hA5A5_A5A5);
        send_item(MODE_APPEND, SYM_PLUS, 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'd7);
        send_item(MODE_CLEAR, 8'h00, 32'd0);
        send_item(MODE_APPEND, "x", 32'd0);
        send_item(MODE_APPEND, "y", 32'd0);
        send_item(MODE_APPEND, "x", 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'd3);
        send_item(MODE_CLEAR, 8'h00, 32'd0);
        send_item(MODE_APPEND, "a", 32'd0);
        send_item(MODE_APPEND, "b", 32'd0);
        send_item(MODE_APPEND, 8'hA1, 32'd0);
        send_item(MODE_CONVERT, 8'h00, 32'd9);

        while (items_sent < ITEM_GOAL) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            shuffle_pool();
            r = $urandom_range(0, 99);
            if (r < 85) begin
                // Mostly clean alphabets; some carry one bad symbol.
                r = $urandom_range(0, 99);
                n = (r < 60) ? $urandom_range(2, 10) :
                    (r < 90) ? $urandom_range(11, 40) : $urandom_range(41, POOL_SIZE);
                bad_at = ($urandom_range(0, 99) < 18) ? $urandom_range(0, n - 1) : -1;
                send_item(MODE_CLEAR, 8'($urandom_range(0, 255)), $urandom);
                for (int i = 0; i < n; i++) begin
                    if (i == bad_at)
                        send_item(MODE_APPEND, pick_bad_symbol(i), $urandom);
                    else
                        send_item(MODE_APPEND, symbol_pool[i], $urandom);
                end
                convert_some((bad_at < 0) ? $urandom_range(1, 5) : $urandom_range(1, 2));
            end else if (r < 95) begin
                repeat ($urandom_range(3, 8))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              pick_value());
            end else begin
                // Load all 92 usable symbols, then append three repeats; the last goes past the limit.
                send_item(MODE_CLEAR, 8'h00, 32'd0);
                for (int i = 0; i < POOL_SIZE; i++)
                    send_item(MODE_APPEND, symbol_pool[i], $urandom);
                convert_some($urandom_range(1, 2));
                for (int i = 0; i < 3; i++)
                    send_item(MODE_APPEND, symbol_pool[i], $urandom);
                convert_some(1);
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (chars_pending != 0);
        repeat (2400) @(posedge aclk);
        if (mismatches == 0 && chars_pending == 0) begin
            $display("radix_number_formatter_test: done, clean");
        end else begin
            $display("radix_number_formatter_test: done, errors");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("radix_number_formatter_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
